// ----- sv/fla_pkg.sv -----
// Shared types and constants for the free-list slot allocator.
// No dependencies; used by every module of the block.
package fla_pkg;

  localparam int SLOT_W              = 8;
  localparam int SLOTS_PER_BLOCK_DEF = 20;
  localparam int MAX_BLOCKS_DEF      = 8;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FREED     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_FILL
  } state_t;

  // One link entry: next-valid flag and next slot.
  typedef struct packed {
    logic              nv;
    logic [SLOT_W-1:0] slot;
  } link_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    link_t             wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
  } res_t;

endpackage

// ----- sv/free_list_slot_allocator_core.sv -----
// Top level of the free-list slot allocator: control, link store, result register.
// Depends on fla_pkg, fla_link_mem and fla_ctrl.
//
// Usage:
//   Input stream: in_tuser = action (0 allocate, 1 free), in_tdata = slot to free.
//   Result stream: out_tdata = slot handed out or echoed (0 on error),
//   out_tuser = status (0 allocated, 1 freed, 2 exhausted, 3 free of unopened slot).
//   Exactly one result per request, in request order.
// Timing:
//   For a free, a rejected request or an allocate from a non-empty list, the
//   result appears in the output register the cycle after its request is
//   accepted. An allocate of any but the last listed slot then reads the link
//   of the new head from the link store (registered read) before the next
//   request is taken. An allocate on an empty list opens a block, if one is
//   left: SLOTS_PER_BLOCK-1 link writes, one per cycle, with the result given
//   alongside the last write.
// Reset: rst_n low clears the list, the block count and the output valid flag.
//   The link store is not cleared; every entry is written before it is read.
// Stall: while a result waits with out_tready low, in_tready stays low; the
//   output register is reloaded in the same cycle it is taken.
module free_list_slot_allocator_core #(
  parameter int SLOTS_PER_BLOCK = fla_pkg::SLOTS_PER_BLOCK_DEF,
  parameter int MAX_BLOCKS      = fla_pkg::MAX_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] slot_index
  input  logic       in_tuser,   // [0] action
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] slot_index_res
  output logic [1:0] out_tuser   // [1:0] status
);

  fla_pkg::mem_req_t mem_req;
  fla_pkg::link_t    mem_rdata;
  fla_pkg::res_t     res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r, out_valid_nxt;
  fla_pkg::res_t     out_res_r;

  assign res_ready = !out_valid_r || out_tready;

  fla_ctrl #(
    .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
    .MAX_BLOCKS      (MAX_BLOCKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (fla_pkg::action_t'(in_tuser)),
    .in_slot   (in_tdata),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  fla_link_mem #(
    .DEPTH (SLOTS_PER_BLOCK * MAX_BLOCKS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.slot;
  assign out_tuser  = out_res_r.status;

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_tready))
    else $error("result produced while output register is occupied");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.status == fla_pkg::ST_EXHAUSTED ||
                   res.status == fla_pkg::ST_BAD_FREE)) |-> (res.slot == '0))
    else $error("error result carries a nonzero slot");

  a_no_mem_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("link store read and write in the same cycle");

endmodule

// ----- sv/fla_link_mem.sv -----
// Link store: one write port, one read port, registered read data.
// Depends on fla_pkg.
module fla_link_mem #(
  parameter int DEPTH = fla_pkg::SLOTS_PER_BLOCK_DEF * fla_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  fla_pkg::mem_req_t req,
  output fla_pkg::link_t    rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fla_pkg::link_t mem [DEPTH];
  fla_pkg::link_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[AW'(req.waddr)] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[AW'(req.raddr)];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/fla_ctrl.sv -----
// Allocator control: free-list head, cached head link, block open sweep.
// Depends on fla_pkg; drives fla_link_mem.
module fla_ctrl #(
  parameter int SLOTS_PER_BLOCK = fla_pkg::SLOTS_PER_BLOCK_DEF,
  parameter int MAX_BLOCKS      = fla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fla_pkg::action_t           in_action,
  input  logic [fla_pkg::SLOT_W-1:0] in_slot,
  input  logic                       res_ready,
  output logic                       res_valid,
  output fla_pkg::res_t              res,
  output fla_pkg::mem_req_t          mem_req,
  input  fla_pkg::link_t             mem_rdata
);

  localparam int POOL_SLOTS = SLOTS_PER_BLOCK * MAX_BLOCKS;
  localparam int NF_W       = $clog2(POOL_SLOTS + 1);
  localparam int BO_W       = $clog2(MAX_BLOCKS + 1);
  localparam int CW         = (NF_W > fla_pkg::SLOT_W) ? NF_W : fla_pkg::SLOT_W;

  fla_pkg::state_t           state_r, state_nxt;
  logic [fla_pkg::SLOT_W-1:0] head_r, head_nxt;
  logic                      hv_r, hv_nxt;
  fla_pkg::link_t            hl_r, hl_nxt;
  logic [BO_W-1:0]           blocks_r, blocks_nxt;
  logic [NF_W-1:0]           nf_r, nf_nxt;
  logic [NF_W-1:0]           fa_r, fa_nxt;
  logic [NF_W-1:0]           fill_last;
  logic                      acc;

  assign fill_last = nf_r + NF_W'(SLOTS_PER_BLOCK - 1);
  assign in_ready  = (state_r == fla_pkg::S_IDLE) && res_ready;
  assign acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fla_pkg::S_IDLE;
      head_r   <= '0;
      hv_r     <= 1'b0;
      hl_r     <= '0;
      blocks_r <= '0;
      nf_r     <= '0;
      fa_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      hv_r     <= hv_nxt;
      hl_r     <= hl_nxt;
      blocks_r <= blocks_nxt;
      nf_r     <= nf_nxt;
      fa_r     <= fa_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    hv_nxt     = hv_r;
    hl_nxt     = hl_r;
    blocks_nxt = blocks_r;
    nf_nxt     = nf_r;
    fa_nxt     = fa_r;
    res_valid  = 1'b0;
    res.slot   = '0;
    res.status = fla_pkg::ST_ALLOCATED;
    mem_req    = '0;

    case (state_r)
      fla_pkg::S_IDLE: begin
        if (acc) begin
          if (in_action == fla_pkg::ACT_ALLOC) begin
            if (hv_r) begin
              // pop head; fetch the new head's link
              res_valid  = 1'b1;
              res.slot   = head_r;
              res.status = fla_pkg::ST_ALLOCATED;
              head_nxt   = hl_r.slot;
              hv_nxt     = hl_r.nv;
              if (hl_r.nv) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = hl_r.slot;
                state_nxt     = fla_pkg::S_LOAD;
              end
            end else if (blocks_r < BO_W'(MAX_BLOCKS)) begin
              fa_nxt    = nf_r + NF_W'(1);
              state_nxt = fla_pkg::S_FILL;
            end else begin
              res_valid  = 1'b1;
              res.status = fla_pkg::ST_EXHAUSTED;
            end
          end else begin
            if (CW'(in_slot) >= CW'(nf_r)) begin
              res_valid  = 1'b1;
              res.status = fla_pkg::ST_BAD_FREE;
            end else begin
              mem_req.we         = 1'b1;
              mem_req.waddr      = in_slot;
              mem_req.wdata.nv   = hv_r;
              mem_req.wdata.slot = head_r;
              hl_nxt.nv          = hv_r;
              hl_nxt.slot        = head_r;
              head_nxt           = in_slot;
              hv_nxt             = 1'b1;
              res_valid          = 1'b1;
              res.slot           = in_slot;
              res.status         = fla_pkg::ST_FREED;
            end
          end
        end
      end

      fla_pkg::S_LOAD: begin
        hl_nxt    = mem_rdata;
        state_nxt = fla_pkg::S_IDLE;
      end

      fla_pkg::S_FILL: begin
        // link slots base+1 .. base+S-1 in ascending order; base is handed out
        mem_req.we    = 1'b1;
        mem_req.waddr = fla_pkg::SLOT_W'(fa_r);
        if (fa_r == fill_last) begin
          mem_req.wdata = '0;
          res_valid     = 1'b1;
          res.slot      = fla_pkg::SLOT_W'(nf_r);
          res.status    = fla_pkg::ST_ALLOCATED;
          head_nxt      = fla_pkg::SLOT_W'(nf_r + NF_W'(1));
          hv_nxt        = 1'b1;
          if (SLOTS_PER_BLOCK > 2) begin
            hl_nxt.nv   = 1'b1;
            hl_nxt.slot = fla_pkg::SLOT_W'(nf_r + NF_W'(2));
          end else begin
            hl_nxt      = '0;
          end
          blocks_nxt = blocks_r + BO_W'(1);
          nf_nxt     = nf_r + NF_W'(SLOTS_PER_BLOCK);
          state_nxt  = fla_pkg::S_IDLE;
        end else begin
          mem_req.wdata.nv   = 1'b1;
          mem_req.wdata.slot = fla_pkg::SLOT_W'(fa_r + NF_W'(1));
          fa_nxt             = fa_r + NF_W'(1);
        end
      end

      default: begin
        state_nxt = fla_pkg::S_IDLE;
      end
    endcase
  end

endmodule
